@@ rtl/pit_pkg.sv @@
// shared types, codes and widths of the periodic interrupt timer
package pit_pkg;

	localparam int REQ_W   = 2;
	localparam int CH_W    = 2;
	localparam int SEL_W   = 3;
	localparam int DATA_W  = 32;
	localparam int IRQ_W   = 4;

	localparam int CHANNELS_DEF    = 4;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

	localparam logic [SEL_W-1:0] REG_MCR   = 3'd0;
	localparam logic [SEL_W-1:0] REG_LOAD  = 3'd1;
	localparam logic [SEL_W-1:0] REG_COUNT = 3'd2;
	localparam logic [SEL_W-1:0] REG_CTRL  = 3'd3;
	localparam logic [SEL_W-1:0] REG_FLAG  = 3'd4;

	localparam int MCR_DIS_BIT  = 1;
	localparam int CTRL_EN_BIT  = 0;
	localparam int CTRL_IE_BIT  = 1;
	localparam int FLAG_BIT     = 0;

	typedef struct packed {
		logic tick;
		logic wr_load;
		logic wr_ctrl;
		logic wr_flag;
	} pit_cmd_t;

	typedef struct packed {
		logic en;
		logic ie;
		logic flag;
	} pit_stat_t;

endpackage

@@ rtl/pit_channel.sv @@
// one timer channel: load, count, control and flag with next-state logic
module pit_channel #(
	parameter int COUNT_WIDTH = pit_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pit_pkg::pit_cmd_t           cmd,
	input  logic [pit_pkg::DATA_W-1:0]  wdata,
	output logic [COUNT_WIDTH-1:0]      load_val,
	output logic [COUNT_WIDTH-1:0]      count_val,
	output pit_pkg::pit_stat_t          stat,
	output logic                        irq_next
);
	import pit_pkg::*;

	logic [COUNT_WIDTH-1:0] load_q, load_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic                   en_q, en_d;
	logic                   ie_q, ie_d;
	logic                   flag_q, flag_d;

	always_comb begin
		load_d  = load_q;
		count_d = count_q;
		en_d    = en_q;
		ie_d    = ie_q;
		flag_d  = flag_q;
		if (cmd.wr_load) begin
			load_d = wdata[COUNT_WIDTH-1:0];
		end
		if (cmd.wr_ctrl) begin
			if (wdata[CTRL_EN_BIT] && !en_q) begin
				count_d = load_q;
			end
			en_d = wdata[CTRL_EN_BIT];
			ie_d = wdata[CTRL_IE_BIT];
		end
		if (cmd.wr_flag && wdata[FLAG_BIT]) begin
			flag_d = 1'b0;
		end
		if (cmd.tick && en_q) begin
			if (count_q == '0) begin
				flag_d  = 1'b1;
				count_d = load_q;
			end else begin
				count_d = count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q  <= '0;
			count_q <= '0;
			en_q    <= 1'b0;
			ie_q    <= 1'b0;
			flag_q  <= 1'b0;
		end else begin
			load_q  <= load_d;
			count_q <= count_d;
			en_q    <= en_d;
			ie_q    <= ie_d;
			flag_q  <= flag_d;
		end
	end

	assign load_val  = load_q;
	assign count_val = count_q;
	assign stat      = '{en: en_q, ie: ie_q, flag: flag_q};
	assign irq_next  = flag_d & ie_d;

endmodule

@@ rtl/periodic_interrupt_timer_core.sv @@
// top level: input register, request decode, channels, read mux and result register
// path: a transfer is held in the input register, then written to the result register once the output is free
// throughput: one item per cycle while the output is not stalled, each item applied in a single registered pass
// an output stall holds the input register and then the input side
// reset: module disabled, all channels stopped with zero load, count and flags
module periodic_interrupt_timer_core #(
	parameter int CHANNELS    = pit_pkg::CHANNELS_DEF,
	parameter int COUNT_WIDTH = pit_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pit_pkg::REQ_W-1:0]   req_type,
	input  logic [pit_pkg::CH_W-1:0]    channel,
	input  logic [pit_pkg::SEL_W-1:0]   reg_select,
	input  logic [pit_pkg::DATA_W-1:0]  write_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pit_pkg::DATA_W-1:0]  read_data,
	output logic [pit_pkg::IRQ_W-1:0]   irq_lines
);
	import pit_pkg::*;

	logic              valid_s1;
	logic [REQ_W-1:0]  req_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [SEL_W-1:0]  sel_s1;
	logic [DATA_W-1:0] data_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic [IRQ_W-1:0]  irq_q;

	logic              mdis_q;
	logic              advance;
	logic              is_tick, is_read, is_write;
	logic [DATA_W-1:0] rdata_d;
	logic [IRQ_W-1:0]  irq_d;

	pit_cmd_t               cmd      [CHANNELS];
	logic [COUNT_WIDTH-1:0] load_val [CHANNELS];
	logic [COUNT_WIDTH-1:0] count_val[CHANNELS];
	pit_stat_t              stat     [CHANNELS];
	logic [CHANNELS-1:0]    irq_next;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign is_tick  = advance && (req_s1 == REQ_TICK);
	assign is_read  = req_s1 == REQ_READ;
	assign is_write = advance && (req_s1 == REQ_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			ch_s1   <= channel;
			sel_s1  <= reg_select;
			data_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdis_q <= 1'b1;
		end else if (is_write && (sel_s1 == REG_MCR)) begin
			mdis_q <= data_s1[MCR_DIS_BIT];
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		logic hit;
		assign hit = is_write && (int'(ch_s1) == c);
		assign cmd[c] = '{
			tick:    is_tick && !mdis_q,
			wr_load: hit && (sel_s1 == REG_LOAD),
			wr_ctrl: hit && (sel_s1 == REG_CTRL),
			wr_flag: hit && (sel_s1 == REG_FLAG)
		};

		pit_channel #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_ch (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd[c]),
			.wdata    (data_s1),
			.load_val (load_val[c]),
			.count_val(count_val[c]),
			.stat     (stat[c]),
			.irq_next (irq_next[c])
		);
	end

	for (genvar c = 0; c < IRQ_W; c++) begin : g_irq
		if (c < CHANNELS) begin : g_on
			assign irq_d[c] = irq_next[c];
		end else begin : g_off
			assign irq_d[c] = 1'b0;
		end
	end

	always_comb begin
		rdata_d = '0;
		if (is_read) begin
			if (sel_s1 == REG_MCR) begin
				rdata_d[MCR_DIS_BIT] = mdis_q;
			end else begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (int'(ch_s1) == c) begin
						unique case (sel_s1)
							REG_LOAD:  rdata_d = DATA_W'(load_val[c]);
							REG_COUNT: rdata_d = DATA_W'(count_val[c]);
							REG_CTRL: begin
								rdata_d[CTRL_EN_BIT] = stat[c].en;
								rdata_d[CTRL_IE_BIT] = stat[c].ie;
							end
							REG_FLAG:  rdata_d[FLAG_BIT] = stat[c].flag;
							default:   rdata_d = '0;
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdata_q <= '0;
			irq_q   <= '0;
		end else if (advance) begin
			rdata_q <= rdata_d;
			irq_q   <= irq_d;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = rdata_q;
	assign irq_lines = irq_q;

endmodule

@@ rtl/pit_checker.sv @@
// port-level checks of the timer core and their bind
module pit_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [pit_pkg::REQ_W-1:0]   req_type,
	input logic [pit_pkg::CH_W-1:0]    channel,
	input logic [pit_pkg::SEL_W-1:0]   reg_select,
	input logic [pit_pkg::DATA_W-1:0]  write_data,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [pit_pkg::DATA_W-1:0]  read_data,
	input logic [pit_pkg::IRQ_W-1:0]   irq_lines
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(req_type) && $stable(channel) &&
			$stable(reg_select) && $stable(write_data))
		else $error("input transfer changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq_lines))
		else $error("result changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input side blocked without output stall");

	a_result_from_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without an input transfer two cycles earlier");

	a_idle_result_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(!out_valid) |-> $stable(irq_lines) && $stable(read_data))
		else $error("result register changed while empty");

endmodule

bind periodic_interrupt_timer_core pit_checker u_pit_checker (.*);

@@ tb/tb_periodic_interrupt_timer_core.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the four-channel periodic interrupt timer: directed table, then random traffic
module tb_periodic_interrupt_timer_core;
	import pit_pkg::*;

	localparam int NCH = CHANNELS_DEF;
	localparam int CW  = COUNT_WIDTH_DEF;

	localparam logic [REQ_W-1:0]  REQ_NONE    = 2'd3;
	localparam logic [SEL_W-1:0]  REG_RSVD_LO = 3'd5;
	localparam logic [SEL_W-1:0]  REG_RSVD_HI = 3'd7;
	localparam logic [DATA_W-1:0] DIS_MASK    = 1 << MCR_DIS_BIT;
	localparam logic [DATA_W-1:0] EN_MASK     = 1 << CTRL_EN_BIT;
	localparam logic [DATA_W-1:0] IE_MASK     = 1 << CTRL_IE_BIT;
	localparam logic [DATA_W-1:0] CLR_MASK    = 1 << FLAG_BIT;
	localparam logic [DATA_W-1:0] ALL_ONES    = '1;

	localparam int RANDOM_ITEMS   = 830;
	localparam int STEADY_FIRST   = 300;
	localparam int STEADY_LAST    = 500;
	localparam int STALL_PCT      = 12;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [CH_W-1:0]   ch;
		logic [SEL_W-1:0]  sel;
		logic [DATA_W-1:0] data;
	} xfer_t;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic [IRQ_W-1:0]  irq;
	} result_t;

	typedef struct packed {
		xfer_t   x;
		logic    fixed;
		result_t res;
	} row_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [REQ_W-1:0]  req_type   = '0;
	logic [CH_W-1:0]   channel    = '0;
	logic [SEL_W-1:0]  reg_select = '0;
	logic [DATA_W-1:0] write_data = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [DATA_W-1:0] read_data;
	logic [IRQ_W-1:0]  irq_lines;

	logic              steady     = 1'b0;
	int                mismatches = 0;
	int                idle_cycles = 0;
	result_t           due_results[$];
	row_t              script[$];

	logic              mod_dis;
	logic [CW-1:0]     load_q[NCH];
	logic [CW-1:0]     cnt_q[NCH];
	logic [NCH-1:0]    en_q;
	logic [NCH-1:0]    ie_q;
	logic [NCH-1:0]    flag_q;

	periodic_interrupt_timer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.channel    (channel),
		.reg_select (reg_select),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.irq_lines  (irq_lines)
	);

	always #5 clk = ~clk;

	function automatic result_t timer_step(input xfer_t x);
		result_t r;
		int c;
		r = '0;
		case (x.req)
			REQ_TICK: begin
				if (!mod_dis) begin
					for (c = 0; c < NCH; c++) begin
						if (en_q[c]) begin
							if (cnt_q[c] == '0) begin
								flag_q[c] = 1'b1;
								cnt_q[c] = load_q[c];
							end else begin
								cnt_q[c] = cnt_q[c] - 1'b1;
							end
						end
					end
				end
			end
			REQ_READ: begin
				if (x.sel == REG_MCR) begin
					r.rd[MCR_DIS_BIT] = mod_dis;
				end else if (int'(x.ch) < NCH) begin
					case (x.sel)
						REG_LOAD:  r.rd = DATA_W'(load_q[x.ch]);
						REG_COUNT: r.rd = DATA_W'(cnt_q[x.ch]);
						REG_CTRL: begin
							r.rd[CTRL_EN_BIT] = en_q[x.ch];
							r.rd[CTRL_IE_BIT] = ie_q[x.ch];
						end
						REG_FLAG:  r.rd[FLAG_BIT] = flag_q[x.ch];
						default:   ;
					endcase
				end
			end
			REQ_WRITE: begin
				if (x.sel == REG_MCR) begin
					mod_dis = x.data[MCR_DIS_BIT];
				end else if (int'(x.ch) < NCH) begin
					case (x.sel)
						REG_LOAD: load_q[x.ch] = x.data[CW-1:0];
						REG_CTRL: begin
							if (x.data[CTRL_EN_BIT] && !en_q[x.ch])
								cnt_q[x.ch] = load_q[x.ch];
							en_q[x.ch] = x.data[CTRL_EN_BIT];
							ie_q[x.ch] = x.data[CTRL_IE_BIT];
						end
						REG_FLAG: begin
							if (x.data[FLAG_BIT])
								flag_q[x.ch] = 1'b0;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		for (c = 0; c < NCH && c < IRQ_W; c++)
			r.irq[c] = flag_q[c] & ie_q[c];
		return r;
	endfunction

	function automatic xfer_t rand_item();
		xfer_t x;
		int p;
		int q;
		x.ch = CH_W'($urandom);
		x.sel = SEL_W'($urandom);
		x.data = $urandom;
		p = $urandom_range(99);
		if (p < 45) begin
			x.req = REQ_TICK;
		end else if (p < 70) begin
			x.req = REQ_READ;
			x.sel = SEL_W'($urandom_range(REG_FLAG));
			if ($urandom_range(9) == 0)
				x.sel = SEL_W'($urandom_range(REG_RSVD_HI, REG_RSVD_LO));
		end else if (p < 96) begin
			x.req = REQ_WRITE;
			q = $urandom_range(99);
			if (q < 10) begin
				x.sel = REG_MCR;
				if ($urandom_range(3) != 0)
					x.data[MCR_DIS_BIT] = 1'b0;
			end else if (q < 40) begin
				x.sel = REG_LOAD;
				if ($urandom_range(7) != 0)
					x.data = $urandom_range(12);
			end else if (q < 65) begin
				x.sel = REG_CTRL;
				x.data[CTRL_EN_BIT] = ($urandom_range(3) != 0);
			end else if (q < 85) begin
				x.sel = REG_FLAG;
			end else if (q < 93) begin
				x.sel = REG_COUNT;
			end else begin
				x.sel = SEL_W'($urandom_range(REG_RSVD_HI, REG_RSVD_LO));
			end
		end else begin
			x.req = REQ_NONE;
		end
		return x;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic step_row(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
			input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] data);
		script.push_back('{x: '{req: req, ch: ch, sel: sel, data: data}, fixed: 1'b0, res: '0});
	endtask

	task automatic check_row(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
			input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] data,
			input logic [DATA_W-1:0] rd, input logic [IRQ_W-1:0] irq);
		script.push_back('{x: '{req: req, ch: ch, sel: sel, data: data}, fixed: 1'b1,
			res: '{rd: rd, irq: irq}});
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(input xfer_t x, input logic fixed, input result_t res);
		result_t want;
		while (!steady && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= x.req;
		channel    <= x.ch;
		reg_select <= x.sel;
		write_data <= x.data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		want = timer_step(x);
		due_results.push_back(fixed ? res : want);
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(99) >= STALL_PCT);

	always @(posedge clk) begin : check_results
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result rd=%h irq=%h with nothing pending",
					read_data, irq_lines));
			end else begin
				e = due_results.pop_front();
				if (read_data !== e.rd)
					report_mismatch($sformatf("read_data %h, expected %h", read_data, e.rd));
				if (irq_lines !== e.irq)
					report_mismatch($sformatf("irq_lines %h, expected %h", irq_lines, e.irq));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int i;
		mod_dis = 1'b1;
		for (i = 0; i < NCH; i++) begin
			load_q[i] = '0;
			cnt_q[i] = '0;
		end
		en_q = '0;
		ie_q = '0;
		flag_q = '0;

		// reset values, reserved selects and the unused request code
		check_row(REQ_READ,  2'd0, REG_MCR,     '0,       DIS_MASK, '0);
		check_row(REQ_READ,  2'd3, REG_LOAD,    '0,       '0,       '0);
		check_row(REQ_READ,  2'd2, REG_COUNT,   '0,       '0,       '0);
		check_row(REQ_READ,  2'd1, REG_RSVD_HI, '0,       '0,       '0);
		check_row(REQ_NONE,  2'd0, REG_MCR,     ALL_ONES, '0,       '0);
		// channel 0 armed while the module is still disabled
		step_row(REQ_WRITE, 2'd0, REG_LOAD,  32'd2);
		step_row(REQ_WRITE, 2'd0, REG_CTRL,  EN_MASK | IE_MASK);
		step_row(REQ_TICK,  2'd0, REG_MCR,   '0);
		step_row(REQ_READ,  2'd0, REG_COUNT, '0);
		step_row(REQ_WRITE, 2'd0, REG_MCR,   '0);
		step_row(REQ_TICK,  2'd0, REG_MCR,   '0);
		step_row(REQ_TICK,  2'd0, REG_MCR,   '0);
		step_row(REQ_TICK,  2'd0, REG_MCR,   '0);
		// load rewritten while running, count write ignored, enable rewritten, flag cleared
		step_row(REQ_WRITE, 2'd0, REG_LOAD,  ALL_ONES);
		step_row(REQ_WRITE, 2'd1, REG_COUNT, 32'd5);
		step_row(REQ_WRITE, 2'd0, REG_CTRL,  EN_MASK | IE_MASK);
		step_row(REQ_WRITE, 2'd0, REG_FLAG,  CLR_MASK);
		// zero load expires on every tick; then channel 0 stopped, reserved and MCR writes, flag read
		step_row(REQ_WRITE, 2'd1, REG_LOAD,  '0);
		step_row(REQ_WRITE, 2'd1, REG_CTRL,  EN_MASK | IE_MASK);
		step_row(REQ_TICK,  2'd0, REG_MCR,   '0);
		step_row(REQ_WRITE, 2'd0, REG_CTRL,  '0);
		step_row(REQ_TICK,  2'd0, REG_MCR,   '0);
		step_row(REQ_READ,  2'd0, REG_COUNT, '0);
		step_row(REQ_WRITE, 2'd2, REG_RSVD_LO, ALL_ONES);
		step_row(REQ_WRITE, 2'd3, REG_MCR,   ~DIS_MASK);
		step_row(REQ_READ,  2'd1, REG_FLAG,  '0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[k])
			send_item(script[k].x, script[k].fixed, script[k].res);
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= STEADY_FIRST) && (i < STEADY_LAST);
			send_item(rand_item(), 1'b0, '0);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ periodic_interrupt_timer_core.f @@
rtl/pit_pkg.sv
rtl/pit_channel.sv
rtl/periodic_interrupt_timer_core.sv
rtl/pit_checker.sv
tb/tb_periodic_interrupt_timer_core.sv
